// ----- hw/rtl/kli_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyframe linear interpolator package
// Shared widths, item kind codes and pose types.
// ----------------------------------------------------------------------------
package kli_pkg;

	localparam int DW = 24;
	localparam int SW = 10;

	localparam logic [1:0] KIND_ADJUST = 2'd0;
	localparam logic [1:0] KIND_SAVE   = 2'd1;
	localparam logic [1:0] KIND_PLAY   = 2'd2;
	localparam logic [1:0] KIND_TICK   = 2'd3;

	localparam logic [SW-1:0] STEPS_RESET = 10'd90;
	localparam logic [SW-1:0] TICK_RESET  = 10'd30;

	typedef logic [DW-1:0] word_t;
	typedef logic signed [DW:0] diff_word_t;

	typedef struct packed {
		word_t z;
		word_t y;
		word_t rot;
	} pose_t;

	typedef struct packed {
		diff_word_t z;
		diff_word_t y;
		diff_word_t rot;
	} diff_t;

endpackage

// ----- hw/rtl/kli_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module kli_ram #(
	parameter int WIDTH = 72,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- hw/rtl/kli_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Three-lane serial divider
// Divides three signed differences by one unsigned step count, one quotient
// bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module kli_div (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  kli_pkg::diff_t         diff,
	input  logic [kli_pkg::SW-1:0] divisor,
	output logic                   done,
	output kli_pkg::pose_t         quot
);
	import kli_pkg::*;

	localparam int CNT_W = $clog2(DW + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;
	logic [SW-1:0]    div_q;
	logic [2:0]       neg_q;
	word_t            q_q   [3];
	logic [SW-1:0]    rem_q [3];
	diff_word_t       d_in  [3];
	diff_word_t       mag   [3];
	logic [SW:0]      trial [3];
	logic             fits  [3];
	word_t            res   [3];

	assign d_in[0] = diff.z;
	assign d_in[1] = diff.y;
	assign d_in[2] = diff.rot;

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			mag[l]   = d_in[l][DW] ? -d_in[l] : d_in[l];
			trial[l] = {rem_q[l], q_q[l][DW-1]};
			fits[l]  = trial[l] >= {1'b0, div_q};
			res[l]   = neg_q[l] ? -q_q[l] : q_q[l];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(DW);
				run_q <= 1'b1;
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= divisor;
			for (int l = 0; l < 3; l++) begin
				neg_q[l] <= d_in[l][DW];
				q_q[l]   <= mag[l][DW-1:0];
				rem_q[l] <= '0;
			end
		end else if (run_q) begin
			for (int l = 0; l < 3; l++) begin
				q_q[l] <= {q_q[l][DW-2:0], fits[l]};
				if (fits[l]) begin
					rem_q[l] <= SW'(trial[l] - {1'b0, div_q});
				end else begin
					rem_q[l] <= trial[l][SW-1:0];
				end
			end
		end
	end

	assign done     = done_q;
	assign quot.z   = res[0];
	assign quot.y   = res[1];
	assign quot.rot = res[2];

endmodule

// ----- hw/rtl/keyframe_linear_interpolator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyframe linear interpolator
// Three-channel Q15.8 keyframe animation engine with a keyframe RAM and a
// serial divider for the per-tick increments.
// ----------------------------------------------------------------------------
//  Channel   Signals                                   Transfer
//  command   start, busy, kind, delta_*                start high, busy low
//  result    done, pose_*, playing, segment, ...       done high, one cycle
//  config    cfg_wr_en, cfg_wr_data                    cfg_wr_en high
//
//  Adjust, save, stop and a plain tick keep busy low and strobe their result in
//  the cycle after the command transfer. A play start or a segment advance reads
//  two keyframes and runs the serial divider; busy stays high until it ends and
//  the result strobe comes as busy falls. Reset clears the pose, increments and
//  counters but the tick count, not the keyframe RAM. Results cannot be held off.
// ----------------------------------------------------------------------------
module keyframe_linear_interpolator #(
	parameter int KEYFRAME_DEPTH = 128
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [1:0]             kind,
	input  logic signed [23:0]     delta_z,
	input  logic signed [23:0]     delta_y,
	input  logic signed [23:0]     delta_rot,
	output logic                   done,
	output logic signed [23:0]     pose_z,
	output logic signed [23:0]     pose_y,
	output logic signed [23:0]     pose_rot,
	output logic                   playing,
	output logic [6:0]             segment,
	output logic [7:0]             frame_count,
	output logic                   store_full,
	input  logic                   cfg_wr_en,
	input  logic [kli_pkg::SW-1:0] cfg_wr_data
);
	import kli_pkg::*;

	localparam int AW = $clog2(KEYFRAME_DEPTH);
	localparam int CW = $clog2(KEYFRAME_DEPTH + 1);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RDA  = 3'd1;
	localparam logic [2:0] S_RDB  = 3'd2;
	localparam logic [2:0] S_DIVS = 3'd3;
	localparam logic [2:0] S_DIV  = 3'd4;

	logic [2:0]    state_q;
	logic          done_q;
	logic          rejected_q;
	logic          active_q;
	logic          load_pose_q;
	logic [CW-1:0] stored_q;
	logic [CW-1:0] seg_q;
	logic [SW-1:0] tick_q;
	logic [SW-1:0] steps_q;
	logic [AW-1:0] addr_q;
	pose_t         cur_q;
	pose_t         step_q;
	pose_t         key_a_q;

	logic          accept;
	logic          full;
	logic [SW-1:0] steps_eff;
	logic [CW-1:0] seg_next;
	logic          last_seg;
	logic          ram_wr_en;
	logic          ram_rd_en;
	logic [AW-1:0] ram_rd_addr;
	pose_t         ram_rd_data;
	diff_t         diff;
	logic          div_start;
	logic          div_done;
	pose_t         quot;

	assign accept    = start && !busy;
	assign busy      = state_q != S_IDLE;
	assign full      = stored_q == CW'(KEYFRAME_DEPTH);
	assign steps_eff = (steps_q == '0) ? SW'(1) : steps_q;
	assign seg_next  = seg_q + 1'b1;
	assign last_seg  = ({1'b0, seg_q} + (CW+1)'(3)) > {1'b0, stored_q};

	assign ram_wr_en   = accept && kind == KIND_SAVE && !full;
	assign ram_rd_en   = state_q == S_RDA || state_q == S_RDB;
	assign ram_rd_addr = (state_q == S_RDA) ? addr_q : addr_q + 1'b1;

	assign diff.z    = {ram_rd_data.z[DW-1], ram_rd_data.z} - {key_a_q.z[DW-1], key_a_q.z};
	assign diff.y    = {ram_rd_data.y[DW-1], ram_rd_data.y} - {key_a_q.y[DW-1], key_a_q.y};
	assign diff.rot  = {ram_rd_data.rot[DW-1], ram_rd_data.rot}
		- {key_a_q.rot[DW-1], key_a_q.rot};
	assign div_start = state_q == S_DIVS;

	kli_ram #(
		.WIDTH($bits(pose_t)),
		.DEPTH(KEYFRAME_DEPTH)
	) u_key_ram (
		.clk    (clk),
		.wr_en  (ram_wr_en),
		.wr_addr(stored_q[AW-1:0]),
		.wr_data(cur_q),
		.rd_en  (ram_rd_en),
		.rd_addr(ram_rd_addr),
		.rd_data(ram_rd_data)
	);

	kli_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.diff   (diff),
		.divisor(steps_eff),
		.done   (div_done),
		.quot   (quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_q <= STEPS_RESET;
		end else if (cfg_wr_en) begin
			steps_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			done_q      <= 1'b0;
			rejected_q  <= 1'b0;
			active_q    <= 1'b0;
			load_pose_q <= 1'b0;
			stored_q    <= '0;
			seg_q       <= '0;
			tick_q      <= TICK_RESET;
			addr_q      <= '0;
			cur_q       <= '0;
			step_q      <= '0;
			key_a_q     <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						rejected_q <= 1'b0;
						done_q     <= 1'b1;
						case (kind)
							KIND_ADJUST: begin
								cur_q.z   <= cur_q.z + word_t'(delta_z);
								cur_q.y   <= cur_q.y + word_t'(delta_y);
								cur_q.rot <= cur_q.rot + word_t'(delta_rot);
							end
							KIND_SAVE: begin
								if (full) begin
									rejected_q <= 1'b1;
								end else begin
									stored_q <= stored_q + 1'b1;
								end
							end
							KIND_PLAY: begin
								if (!active_q && stored_q > CW'(1)) begin
									seg_q       <= '0;
									tick_q      <= '0;
									active_q    <= 1'b1;
									addr_q      <= '0;
									load_pose_q <= 1'b1;
									done_q      <= 1'b0;
									state_q     <= S_RDA;
								end else begin
									active_q <= 1'b0;
								end
							end
							default: begin
								if (active_q) begin
									if (tick_q >= steps_eff) begin
										if (last_seg) begin
											seg_q    <= '0;
											active_q <= 1'b0;
										end else begin
											seg_q       <= seg_next;
											tick_q      <= '0;
											addr_q      <= seg_next[AW-1:0];
											load_pose_q <= 1'b0;
											done_q      <= 1'b0;
											state_q     <= S_RDA;
										end
									end else begin
										cur_q.z   <= cur_q.z + step_q.z;
										cur_q.y   <= cur_q.y + step_q.y;
										cur_q.rot <= cur_q.rot + step_q.rot;
										tick_q    <= tick_q + 1'b1;
									end
								end
							end
						endcase
					end
				end
				S_RDA: begin
					state_q <= S_RDB;
				end
				S_RDB: begin
					key_a_q <= ram_rd_data;
					if (load_pose_q) begin
						cur_q <= ram_rd_data;
					end
					state_q <= S_DIVS;
				end
				S_DIVS: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_done) begin
						step_q  <= quot;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done        = done_q;
	assign pose_z      = $signed(cur_q.z);
	assign pose_y      = $signed(cur_q.y);
	assign pose_rot    = $signed(cur_q.rot);
	assign playing     = active_q;
	assign segment     = 7'(seg_q);
	assign frame_count = 8'(stored_q);
	assign store_full  = rejected_q;

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyframe linear interpolator testbench
// Drives adjust, save, play/stop and tick commands, both directed and random,
// across several step counts. It tracks its own copy of the pose, keyframes
// and playback state, and compares every result strobe field by field.
// ----------------------------------------------------------------------------
module tb;

	import kli_pkg::*;

	localparam int KEYFRAME_DEPTH = 128;
	localparam int STALL_LIMIT    = 2000;
	localparam int SETTLE_CYCLES  = 40;
	localparam int EXP_DEPTH      = 16;

	typedef struct packed {
		pose_t      pose;
		logic       playing;
		logic [6:0] seg;
		logic [7:0] count;
		logic       full;
	} frame_result_t;

	logic              clk         = 1'b0;
	logic              arst_n      = 1'b0;
	logic              start       = 1'b0;
	logic [1:0]        kind        = KIND_ADJUST;
	word_t             delta_z     = '0;
	word_t             delta_y     = '0;
	word_t             delta_rot   = '0;
	logic              cfg_wr_en   = 1'b0;
	logic [SW-1:0]     cfg_wr_data = '0;
	logic              busy;
	logic              done;
	logic signed [23:0] pose_z;
	logic signed [23:0] pose_y;
	logic signed [23:0] pose_rot;
	logic              playing;
	logic [6:0]        segment;
	logic [7:0]        frame_count;
	logic              store_full;

	pose_t         keyframes [KEYFRAME_DEPTH];
	pose_t         pose_now   = '0;
	pose_t         pose_inc   = '0;
	logic          active_now = 1'b0;
	int            seg_now    = 0;
	logic [SW-1:0] tick_now   = TICK_RESET;
	int            saved      = 0;
	logic [SW-1:0] steps_reg  = STEPS_RESET;

	frame_result_t expected_frames [EXP_DEPTH];
	int            exp_wr  = 0;
	int            exp_rd  = 0;
	int            errors  = 0;
	bit            gaps_on = 1'b1;

	always #5 clk = ~clk;

	keyframe_linear_interpolator #(
		.KEYFRAME_DEPTH(KEYFRAME_DEPTH)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.kind       (kind),
		.delta_z    (delta_z),
		.delta_y    (delta_y),
		.delta_rot  (delta_rot),
		.done       (done),
		.pose_z     (pose_z),
		.pose_y     (pose_y),
		.pose_rot   (pose_rot),
		.playing    (playing),
		.segment    (segment),
		.frame_count(frame_count),
		.store_full (store_full),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	function automatic int eff_steps();
		return (steps_reg == 0) ? 1 : int'(steps_reg);
	endfunction

	function automatic word_t seg_delta(word_t from_w, word_t to_w);
		longint d;
		d = longint'($signed(to_w)) - longint'($signed(from_w));
		d = d / longint'(eff_steps());
		return d[DW-1:0];
	endfunction

	function automatic void load_increments();
		pose_inc.z   = seg_delta(keyframes[seg_now].z, keyframes[seg_now + 1].z);
		pose_inc.y   = seg_delta(keyframes[seg_now].y, keyframes[seg_now + 1].y);
		pose_inc.rot = seg_delta(keyframes[seg_now].rot, keyframes[seg_now + 1].rot);
	endfunction

	function automatic frame_result_t next_frame(logic [1:0] k, word_t dz, word_t dy,
			word_t dr);
		frame_result_t r;
		logic rejected;
		rejected = 1'b0;
		case (k)
			KIND_ADJUST: begin
				pose_now.z   = pose_now.z + dz;
				pose_now.y   = pose_now.y + dy;
				pose_now.rot = pose_now.rot + dr;
			end
			KIND_SAVE: begin
				if (saved >= KEYFRAME_DEPTH) begin
					rejected = 1'b1;
				end else begin
					keyframes[saved] = pose_now;
					saved++;
				end
			end
			KIND_PLAY: begin
				if (!active_now && saved > 1) begin
					pose_now   = keyframes[0];
					seg_now    = 0;
					load_increments();
					active_now = 1'b1;
					tick_now   = '0;
				end else begin
					active_now = 1'b0;
				end
			end
			default: begin
				if (active_now) begin
					if (int'(tick_now) >= eff_steps()) begin
						seg_now++;
						if (seg_now + 2 > saved) begin
							seg_now    = 0;
							active_now = 1'b0;
						end else begin
							tick_now = '0;
							load_increments();
						end
					end else begin
						pose_now.z   = pose_now.z + pose_inc.z;
						pose_now.y   = pose_now.y + pose_inc.y;
						pose_now.rot = pose_now.rot + pose_inc.rot;
						tick_now     = tick_now + 1'b1;
					end
				end
			end
		endcase
		r.pose    = pose_now;
		r.playing = active_now;
		r.seg     = seg_now[6:0];
		r.count   = saved[7:0];
		r.full    = rejected;
		return r;
	endfunction

	function automatic void check_field(string name, logic [DW-1:0] want,
			logic [DW-1:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
		end
	endfunction

	// Result checker and stall watchdog.
	always @(posedge clk) begin
		frame_result_t want;
		int stall_cycles;
		if (arst_n && ((start && !busy) || done)) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
		end
		if (stall_cycles >= STALL_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
		if (arst_n && done) begin
			if (exp_wr == exp_rd) begin
				errors++;
				$display("%0t: result transfer with no expected frame", $time);
			end else begin
				want = expected_frames[exp_rd % EXP_DEPTH];
				exp_rd++;
				check_field("pose_z", want.pose.z, pose_z);
				check_field("pose_y", want.pose.y, pose_y);
				check_field("pose_rot", want.pose.rot, pose_rot);
				check_field("playing", DW'(want.playing), DW'(playing));
				check_field("segment", DW'(want.seg), DW'(segment));
				check_field("frame_count", DW'(want.count), DW'(frame_count));
				check_field("store_full", DW'(want.full), DW'(store_full));
			end
		end
	end

	function automatic int pick_gap();
		int r;
		if (!gaps_on) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end
		if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(4, 40);
	endfunction

	function automatic word_t rand_word();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			return word_t'($urandom);
		end
		if (r < 85) begin
			return word_t'($urandom_range(0, 511) - 256);
		end
		case ($urandom_range(0, 3))
			0: return 24'h7FFFFF;
			1: return 24'h800000;
			2: return 24'h000000;
			default: return 24'hFFFFFF;
		endcase
	endfunction

	task automatic send_cmd(logic [1:0] k, word_t dz, word_t dy, word_t dr);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start     <= 1'b1;
		kind      <= k;
		delta_z   <= dz;
		delta_y   <= dy;
		delta_rot <= dr;
		do @(posedge clk); while (busy);
		expected_frames[exp_wr % EXP_DEPTH] = next_frame(k, dz, dy, dr);
		exp_wr++;
	endtask

	task automatic send_kind(logic [1:0] k);
		send_cmd(k, rand_word(), rand_word(), rand_word());
	endtask

	task automatic set_steps(logic [SW-1:0] v);
		start <= 1'b0;
		while (exp_wr != exp_rd) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		steps_reg = v;
		cfg_wr_en <= 1'b0;
	endtask

	task automatic test_adjust_extremes();
		send_cmd(KIND_ADJUST, 24'h7FFFFF, 24'h800000, 24'h000001);
		send_cmd(KIND_ADJUST, 24'h7FFFFF, 24'h7FFFFF, 24'hFFFFFF);
		send_cmd(KIND_ADJUST, 24'h800000, 24'h800000, 24'h800000);
	endtask

	task automatic test_play_guard();
		send_kind(KIND_PLAY);
		send_kind(KIND_TICK);
		send_kind(KIND_SAVE);
		send_kind(KIND_PLAY);
		send_kind(KIND_TICK);
	endtask

	task automatic test_zero_steps();
		set_steps('0);
		send_cmd(KIND_ADJUST, 24'h7FFFFF, 24'h800000, 24'h123456);
		send_kind(KIND_SAVE);
		send_kind(KIND_PLAY);
		send_kind(KIND_TICK);
		send_kind(KIND_TICK);
		send_kind(KIND_TICK);
	endtask

	task automatic test_stop_and_edit();
		set_steps(10'd1023);
		send_kind(KIND_PLAY);
		send_kind(KIND_TICK);
		send_kind(KIND_TICK);
		send_kind(KIND_ADJUST);
		send_kind(KIND_SAVE);
		send_kind(KIND_PLAY);
		send_kind(KIND_PLAY);
		send_kind(KIND_TICK);
		send_kind(KIND_PLAY);
	endtask

	// Mostly keyframe building while stopped and tick runs while playing.
	task automatic test_random(logic [SW-1:0] steps, int count);
		int i;
		int r;
		set_steps(steps);
		for (i = 0; i < count; i++) begin
			if (i % 50 == 0) begin
				gaps_on = ($urandom_range(0, 3) != 0);
			end
			r = $urandom_range(0, 99);
			if (active_now) begin
				if (r < 84) begin
					send_kind(KIND_TICK);
				end else if (r < 92) begin
					send_kind(KIND_ADJUST);
				end else if (r < 97) begin
					send_kind(KIND_SAVE);
				end else begin
					send_kind(KIND_PLAY);
				end
			end else begin
				if (r < 50) begin
					send_kind(KIND_ADJUST);
				end else if (r < 65) begin
					send_kind(KIND_SAVE);
				end else if (r < 90) begin
					send_kind(KIND_PLAY);
				end else begin
					send_kind(KIND_TICK);
				end
			end
		end
		gaps_on = 1'b1;
	endtask

	task automatic test_store_full();
		set_steps(10'd1);
		if (active_now) begin
			send_kind(KIND_PLAY);
		end
		while (saved < KEYFRAME_DEPTH) begin
			send_kind(KIND_SAVE);
			if ($urandom_range(0, 1) != 0) begin
				send_kind(KIND_ADJUST);
			end
		end
		repeat (3) send_kind(KIND_SAVE);
		send_kind(KIND_PLAY);
		while (active_now) begin
			send_kind(KIND_TICK);
		end
		send_kind(KIND_TICK);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_adjust_extremes();
		test_play_guard();
		test_zero_steps();
		test_stop_and_edit();
		test_random(10'd1, 300);
		test_random(10'd2, 300);
		test_random(SW'($urandom_range(3, 12)), 300);
		test_random(10'd1023, 250);
		test_random(SW'($urandom_range(5, 40)), 300);
		test_store_full();
		start <= 1'b0;
		while (exp_wr != exp_rd) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
